// ===== rtl/base64_codec_with_line_wrap_core_macros.svh =====
// assertion macros used by the result buffer of the base64 codec rtl
`ifndef BASE64_CODEC_WITH_LINE_WRAP_CORE_MACROS_SVH
`define BASE64_CODEC_WITH_LINE_WRAP_CORE_MACROS_SVH

// same-cycle implication, clocked on clock and disabled in reset
`define B64LW_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, clocked on clock and disabled in reset
`define B64LW_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/b64lw_pkg.sv =====
// types, constants and helper functions of the base64 codec
package b64lw_pkg;

   localparam int MaxRes = 6;
   localparam int ResCountWidth = $clog2(MaxRes + 1);

   localparam logic [7:0] CharPad = 8'h3D;
   localparam logic [7:0] CharNewline = 8'h0A;
   localparam logic [15:0] WrapWidthReset = 16'd76;

   typedef enum logic [1:0] {
      CSR_DECODE_MODE,
      CSR_IGNORE_GARBAGE,
      CSR_WRAP_WIDTH
   } b64lw_csr_index_type;

   typedef enum logic [1:0] {
      CK_DATA,
      CK_PAD,
      CK_NEWLINE,
      CK_BAD
   } b64lw_char_kind_type;

   typedef struct packed {
      b64lw_char_kind_type kind;
      logic [5:0]          value;
   } b64lw_char_type;

   typedef struct packed {
      logic        decode_mode;
      logic        ignore_garbage;
      logic [15:0] wrap_width;
   } b64lw_cfg_type;

   typedef struct packed {
      logic [7:0] data;
      logic       err;
   } b64lw_res_type;

   typedef struct packed {
      logic                       load;
      logic [ResCountWidth-1:0]   count;
      b64lw_res_type [MaxRes-1:0] res;
   } b64lw_batch_type;

   // six-bit value to alphabet character
   function automatic logic [7:0] b64lw_encode_char(input logic [5:0] v);
      logic [7:0] r;
      if (v < 6'd26) begin
         r = 8'h41 + {2'b00, v};
      end else if (v < 6'd52) begin
         r = 8'h61 + {2'b00, v} - 8'd26;
      end else if (v < 6'd62) begin
         r = 8'h30 + {2'b00, v} - 8'd52;
      end else if (v == 6'd62) begin
         r = 8'h2B;
      end else begin
         r = 8'h2F;
      end
      return r;
   endfunction

   // character to kind and six-bit value
   function automatic b64lw_char_type b64lw_decode_char(input logic [7:0] c);
      b64lw_char_type r;
      r.kind = CK_DATA;
      r.value = '0;
      case (c) inside
         [8'h41:8'h5A]: r.value = 6'(c - 8'h41);
         [8'h61:8'h7A]: r.value = 6'(c - 8'h61 + 8'd26);
         [8'h30:8'h39]: r.value = 6'(c - 8'h30 + 8'd52);
         8'h2B:         r.value = 6'd62;
         8'h2F:         r.value = 6'd63;
         CharPad:       r.kind = CK_PAD;
         CharNewline:   r.kind = CK_NEWLINE;
         default:       r.kind = CK_BAD;
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/b64lw_intf.sv =====
// channel interfaces of the base64 codec

interface b64lw_req_if;
   logic       valid;
   logic       ready;
   logic       cmd;
   logic [7:0] in_byte;
   modport source (output valid, output cmd, output in_byte, input ready);
   modport sink (input valid, input cmd, input in_byte, output ready);
endinterface

interface b64lw_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       error;
   logic       last;
   modport source (output valid, output out_byte, output error, output last, input ready);
   modport sink (input valid, input out_byte, input error, input last, output ready);
endinterface

interface b64lw_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [15:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/b64lw_csr_regs.sv =====
// configuration registers of the base64 codec
module b64lw_csr_regs
   import b64lw_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   b64lw_csr_if.sink     csr_ch,
   output b64lw_cfg_type cfg
);

   b64lw_cfg_type cfg_ff;

   assign csr_ch.ready = 1'b1;
   assign cfg = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.decode_mode <= 1'b0;
         cfg_ff.ignore_garbage <= 1'b0;
         cfg_ff.wrap_width <= WrapWidthReset;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_DECODE_MODE:    cfg_ff.decode_mode <= csr_ch.data[0];
            CSR_IGNORE_GARBAGE: cfg_ff.ignore_garbage <= csr_ch.data[0];
            CSR_WRAP_WIDTH:     cfg_ff.wrap_width <= csr_ch.data;
            default: ;
         endcase
      end
   end

endmodule

// ===== rtl/b64lw_step.sv =====
// stream state and per-transaction result generation
module b64lw_step
   import b64lw_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            accept,
   input  logic            cmd,
   input  logic [7:0]      in_byte,
   input  b64lw_cfg_type   cfg,
   output b64lw_batch_type batch
);

   logic [1:0]  gp_ff, gp_in;
   logic [5:0]  carry_ff, carry_in;
   logic        pad_ff, pad_in;
   logic [15:0] col_ff, col_in;
   logic        err_ff, err_in;

   always_comb begin
      b64lw_char_type           dec;
      logic [2:0][7:0]          chars;
      logic [1:0]               nch;
      logic                     flush_nl;
      logic [15:0]              col;
      logic [ResCountWidth-1:0] n;
      b64lw_res_type [MaxRes-1:0] res;

      gp_in = gp_ff;
      carry_in = carry_ff;
      pad_in = pad_ff;
      err_in = err_ff;
      chars = '0;
      nch = '0;
      flush_nl = 1'b0;
      col = col_ff;
      n = '0;
      res = '0;
      dec = b64lw_decode_char(in_byte);

      if (!cmd) begin
         if (!cfg.decode_mode) begin
            case (gp_ff)
               2'd0: begin
                  chars[0] = b64lw_encode_char(in_byte[7:2]);
                  nch = 2'd1;
                  carry_in = {4'b0, in_byte[1:0]};
                  gp_in = 2'd1;
               end
               2'd1: begin
                  chars[0] = b64lw_encode_char({carry_ff[1:0], in_byte[7:4]});
                  nch = 2'd1;
                  carry_in = {2'b0, in_byte[3:0]};
                  gp_in = 2'd2;
               end
               default: begin
                  chars[0] = b64lw_encode_char({carry_ff[3:0], in_byte[7:6]});
                  chars[1] = b64lw_encode_char(in_byte[5:0]);
                  nch = 2'd2;
                  carry_in = '0;
                  gp_in = 2'd0;
               end
            endcase
         end else if (!err_ff && dec.kind != CK_NEWLINE) begin
            if (dec.kind == CK_BAD) begin
               if (!cfg.ignore_garbage) begin
                  res[n] = '{data: 8'h00, err: 1'b1};
                  n = n + 1'b1;
                  err_in = 1'b1;
               end
            end else if ((dec.kind == CK_PAD && gp_ff < 2'd2) ||
                         (dec.kind == CK_DATA && pad_ff)) begin
               res[n] = '{data: 8'h00, err: 1'b1};
               n = n + 1'b1;
               err_in = 1'b1;
            end else begin
               case (gp_ff)
                  2'd0: begin
                     carry_in = dec.value;
                     gp_in = 2'd1;
                  end
                  2'd1: begin
                     res[n] = '{data: {carry_ff, dec.value[5:4]}, err: 1'b0};
                     n = n + 1'b1;
                     carry_in = {2'b0, dec.value[3:0]};
                     gp_in = 2'd2;
                  end
                  2'd2: begin
                     if (dec.kind == CK_PAD) begin
                        pad_in = 1'b1;
                        carry_in = '0;
                     end else begin
                        res[n] = '{data: {carry_ff[3:0], dec.value[5:2]}, err: 1'b0};
                        n = n + 1'b1;
                        carry_in = {4'b0, dec.value[1:0]};
                     end
                     gp_in = 2'd3;
                  end
                  default: begin
                     if (dec.kind == CK_PAD) begin
                        pad_in = 1'b0;
                     end else begin
                        res[n] = '{data: {carry_ff[1:0], dec.value}, err: 1'b0};
                        n = n + 1'b1;
                     end
                     carry_in = '0;
                     gp_in = 2'd0;
                  end
               endcase
            end
         end
      end else begin
         if (cfg.decode_mode) begin
            if (err_ff || gp_ff != 2'd0) begin
               res[n] = '{data: 8'h00, err: 1'b1};
               n = n + 1'b1;
            end
         end else begin
            case (gp_ff)
               2'd1: begin
                  chars[0] = b64lw_encode_char({carry_ff[1:0], 4'b0});
                  chars[1] = CharPad;
                  chars[2] = CharPad;
                  nch = 2'd3;
               end
               2'd2: begin
                  chars[0] = b64lw_encode_char({carry_ff[3:0], 2'b0});
                  chars[1] = CharPad;
                  nch = 2'd2;
               end
               default: ;
            endcase
            flush_nl = 1'b1;
         end
      end

      // emit characters with line wrapping
      for (int i = 0; i < 3; i++) begin
         if (2'(i) < nch) begin
            res[n] = '{data: chars[i], err: 1'b0};
            n = n + 1'b1;
            col = col + 16'd1;
            if (cfg.wrap_width != 16'd0 && col >= cfg.wrap_width) begin
               res[n] = '{data: CharNewline, err: 1'b0};
               n = n + 1'b1;
               col = '0;
            end
         end
      end
      if (flush_nl && cfg.wrap_width != 16'd0 && col != 16'd0) begin
         res[n] = '{data: CharNewline, err: 1'b0};
         n = n + 1'b1;
      end

      col_in = col;
      if (cmd) begin
         gp_in = '0;
         carry_in = '0;
         pad_in = 1'b0;
         col_in = '0;
         err_in = 1'b0;
      end

      batch.load = accept;
      batch.count = n;
      batch.res = res;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gp_ff <= '0;
         carry_ff <= '0;
         pad_ff <= 1'b0;
         col_ff <= '0;
         err_ff <= 1'b0;
      end else if (accept) begin
         gp_ff <= gp_in;
         carry_ff <= carry_in;
         pad_ff <= pad_in;
         col_ff <= col_in;
         err_ff <= err_in;
      end
   end

endmodule

// ===== rtl/b64lw_resbuf.sv =====
// result buffer and output register
module b64lw_resbuf
   import b64lw_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  b64lw_batch_type batch,
   output logic            take_ok,
   b64lw_rsp_if.source     rsp_ch
);

`include "base64_codec_with_line_wrap_core_macros.svh"

   b64lw_res_type [MaxRes-1:0] buf_ff;
   logic [ResCountWidth-1:0]   cnt_ff;
   logic [ResCountWidth-1:0]   idx_ff;
   logic                       valid_ff;
   logic [7:0]                 data_ff;
   logic                       err_ff;
   logic                       last_ff;
   logic                       pop;
   logic                       final_sel;

   assign final_sel = (idx_ff + 1'b1) == cnt_ff;
   assign pop = (idx_ff != cnt_ff) && (!valid_ff || rsp_ch.ready);
   assign take_ok = (idx_ff == cnt_ff) || (pop && final_sel);

   assign rsp_ch.valid = valid_ff;
   assign rsp_ch.out_byte = data_ff;
   assign rsp_ch.error = err_ff;
   assign rsp_ch.last = last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         idx_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         if (batch.load) begin
            cnt_ff <= batch.count;
            idx_ff <= '0;
         end else if (pop) begin
            idx_ff <= idx_ff + 1'b1;
         end
         if (pop) begin
            valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (batch.load) begin
         buf_ff <= batch.res;
      end
      if (pop) begin
         data_ff <= buf_ff[idx_ff].data;
         err_ff <= buf_ff[idx_ff].err;
         last_ff <= final_sel;
      end
   end

   `B64LW_ASSERT_NOW(a_idx_bound, 1'b1, idx_ff <= cnt_ff, "read index past result count")
   `B64LW_ASSERT_NEXT(a_final_last, pop && final_sel, valid_ff && last_ff, "final result lacks last")
   `B64LW_ASSERT_NOW(a_err_zero, valid_ff && err_ff, data_ff == 8'h00, "error result with data")
   `B64LW_ASSERT_NEXT(a_load_pending, batch.load && batch.count != '0, idx_ff != cnt_ff,
                      "loaded results not pending")

endmodule

// ===== rtl/base64_codec_with_line_wrap_core.sv =====
// accepted results go to the result buffer, then one by one to the output register
// throughput: one transaction per cycle when it yields at most one result and the
// receiver accepts; else a new one waits while the single-entry output register
// drains the buffer; transactions that yield no result do not occupy it
// reset: synchronous, clears stream state and buffers, loads configuration defaults
// top level of the base64 codec with line wrapping
module base64_codec_with_line_wrap_core
   import b64lw_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   b64lw_req_if.sink   req_ch,
   b64lw_rsp_if.source rsp_ch,
   b64lw_csr_if.sink   csr_ch
);

   b64lw_cfg_type   cfg;
   b64lw_batch_type batch;
   logic            take_ok;
   logic            accept;

   assign req_ch.ready = take_ok;
   assign accept = req_ch.valid && take_ok;

   b64lw_csr_regs u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .cfg    (cfg)
   );

   b64lw_step u_step (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .cmd     (req_ch.cmd),
      .in_byte (req_ch.in_byte),
      .cfg     (cfg),
      .batch   (batch)
   );

   b64lw_resbuf u_resbuf (
      .clock   (clock),
      .reset   (reset),
      .batch   (batch),
      .take_ok (take_ok),
      .rsp_ch  (rsp_ch)
   );

endmodule

// ===== tb/base64_codec_with_line_wrap_core_test.sv =====
// testbench of the base64 codec: directed and random encode/decode streams checked by a predictor
module base64_codec_with_line_wrap_core_test;
   import b64lw_pkg::*;

   localparam logic CMD_DATA = 1'b0;
   localparam logic CMD_END = 1'b1;
   localparam int CYCLE_LIMIT = 300000;
   localparam int SETTLE_CYCLES = 12;
   localparam int DRAIN_LIMIT = 20000;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       error;
      logic       last;
   } codec_out_type;

   logic clock = 1'b0;
   logic reset;

   b64lw_req_if req_ch ();
   b64lw_rsp_if rsp_ch ();
   b64lw_csr_if csr_ch ();

   base64_codec_with_line_wrap_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always #2 clock = ~clock;

   // predictor copy of configuration and stream state
   logic        mode_dec;
   logic        ign_garbage;
   logic [15:0] wrap_w;
   logic [1:0]  grp_pos;
   logic [5:0]  carry;
   logic        pad_pend;
   logic [15:0] col;
   logic        err_lat;

   codec_out_type awaited_outputs[$];
   codec_out_type item_outputs[$];

   int mismatches = 0;
   int items_sent = 0;
   int outputs_checked = 0;
   int streams_closed = 0;
   int burst_left = 0;
   int hold_left = 0;
   bit tx_no_gaps = 1'b0;

   function automatic logic [7:0] sextet_char(input logic [5:0] v);
      if (v < 6'd26) return {2'b00, v} + 8'h41;
      if (v < 6'd52) return {2'b00, v} + 8'h47;
      if (v < 6'd62) return {2'b00, v} - 8'd4;
      if (v == 6'd62) return 8'h2B;
      return 8'h2F;
   endfunction

   // 0..63 alphabet, 64 pad, -1 anything else
   function automatic int sextet_of(input logic [7:0] c);
      if (c >= 8'h41 && c <= 8'h5A) return int'(c) - 65;
      if (c >= 8'h61 && c <= 8'h7A) return int'(c) - 71;
      if (c >= 8'h30 && c <= 8'h39) return int'(c) + 4;
      if (c == 8'h2B) return 62;
      if (c == 8'h2F) return 63;
      if (c == CharPad) return 64;
      return -1;
   endfunction

   function automatic void emit(input logic [7:0] b, input logic e);
      codec_out_type o;
      if (item_outputs.size() < MaxRes) begin
         o.out_byte = b;
         o.error = e;
         o.last = 1'b0;
         item_outputs.push_back(o);
      end
   endfunction

   function automatic void put_symbol(input logic [7:0] ch);
      emit(ch, 1'b0);
      col = col + 16'd1;
      if (wrap_w != 16'd0 && col >= wrap_w) begin
         emit(CharNewline, 1'b0);
         col = '0;
      end
   endfunction

   function automatic void flag_error();
      err_lat = 1'b1;
      emit(8'h00, 1'b1);
   endfunction

   function automatic void clear_stream();
      grp_pos = '0;
      carry = '0;
      pad_pend = 1'b0;
      col = '0;
      err_lat = 1'b0;
   endfunction

   function automatic void encode_one(input logic [7:0] b);
      case (grp_pos)
         2'd0: begin
            put_symbol(sextet_char(b[7:2]));
            carry = {4'b0000, b[1:0]};
            grp_pos = 2'd1;
         end
         2'd1: begin
            put_symbol(sextet_char({carry[1:0], b[7:4]}));
            carry = {2'b00, b[3:0]};
            grp_pos = 2'd2;
         end
         default: begin
            put_symbol(sextet_char({carry[3:0], b[7:6]}));
            put_symbol(sextet_char(b[5:0]));
            carry = '0;
            grp_pos = 2'd0;
         end
      endcase
   endfunction

   function automatic void encode_flush();
      if (grp_pos == 2'd1) begin
         put_symbol(sextet_char({carry[1:0], 4'b0000}));
         put_symbol(CharPad);
         put_symbol(CharPad);
      end else if (grp_pos == 2'd2) begin
         put_symbol(sextet_char({carry[3:0], 2'b00}));
         put_symbol(CharPad);
      end
      if (wrap_w != 16'd0 && col != 16'd0) emit(CharNewline, 1'b0);
   endfunction

   function automatic void decode_one(input logic [7:0] c);
      int v;
      logic pad;
      if (err_lat || c == CharNewline) return;
      v = sextet_of(c);
      if (v < 0) begin
         if (!ign_garbage) flag_error();
         return;
      end
      pad = (v == 64);
      if (pad) begin
         if (grp_pos < 2'd2) begin
            flag_error();
            return;
         end
      end else if (pad_pend) begin
         flag_error();
         return;
      end
      case (grp_pos)
         2'd0: begin
            carry = v[5:0];
            grp_pos = 2'd1;
         end
         2'd1: begin
            emit({carry, v[5:4]}, 1'b0);
            carry = {2'b00, v[3:0]};
            grp_pos = 2'd2;
         end
         2'd2: begin
            if (pad) begin
               pad_pend = 1'b1;
               carry = '0;
            end else begin
               emit({carry[3:0], v[5:2]}, 1'b0);
               carry = {4'b0000, v[1:0]};
            end
            grp_pos = 2'd3;
         end
         default: begin
            if (pad) pad_pend = 1'b0;
            else emit({carry[1:0], v[5:0]}, 1'b0);
            carry = '0;
            grp_pos = 2'd0;
         end
      endcase
   endfunction

   function automatic void compute_codec_outputs(input logic cmd, input logic [7:0] b);
      codec_out_type o;
      item_outputs.delete();
      if (cmd == CMD_DATA) begin
         if (mode_dec) decode_one(b);
         else encode_one(b);
      end else begin
         if (mode_dec) begin
            if (err_lat || grp_pos != 2'd0) emit(8'h00, 1'b1);
         end else begin
            encode_flush();
         end
         clear_stream();
      end
      foreach (item_outputs[i]) begin
         o = item_outputs[i];
         o.last = (i == item_outputs.size() - 1);
         awaited_outputs.push_back(o);
      end
   endfunction

   function automatic void apply_register(input b64lw_csr_index_type idx,
                                          input logic [15:0] value);
      case (idx)
         CSR_DECODE_MODE: mode_dec = value[0];
         CSR_IGNORE_GARBAGE: ign_garbage = value[0];
         CSR_WRAP_WIDTH: wrap_w = value;
         default: ;
      endcase
   endfunction

   function automatic logic [7:0] random_symbol();
      return sextet_char(6'($urandom_range(0, 63)));
   endfunction

   task automatic send_item(input logic cmd, input logic [7:0] b);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = (tx_no_gaps || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            @(negedge clock);
            req_ch.valid = 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_ch.valid = 1'b1;
      req_ch.cmd = cmd;
      req_ch.in_byte = b;
      do @(posedge clock); while (!req_ch.ready);
      compute_codec_outputs(cmd, b);
      items_sent++;
      if (cmd == CMD_END) streams_closed++;
   endtask

   task automatic send_end();
      send_item(CMD_END, 8'($urandom_range(0, 255)));
   endtask

   task automatic write_reg(input b64lw_csr_index_type idx, input logic [15:0] value);
      @(negedge clock);
      csr_ch.valid = 1'b1;
      csr_ch.index = idx;
      csr_ch.data = value;
      do @(posedge clock); while (!csr_ch.ready);
      apply_register(idx, value);
      @(negedge clock);
      csr_ch.valid = 1'b0;
   endtask

   // stop offering, wait out every awaited output and any result-free transaction
   task automatic settle();
      @(negedge clock);
      req_ch.valid = 1'b0;
      burst_left = 0;
      while (awaited_outputs.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic check_output(input logic [7:0] b, input logic e, input logic l);
      codec_out_type exp;
      outputs_checked++;
      if (awaited_outputs.size() == 0) begin
         $display("%0t: unexpected output byte %h error %b last %b", $time, b, e, l);
         mismatches++;
         return;
      end
      exp = awaited_outputs.pop_front();
      if (b !== exp.out_byte) begin
         $display("%0t: out_byte expected %h actual %h", $time, exp.out_byte, b);
         mismatches++;
      end
      if (e !== exp.error) begin
         $display("%0t: error expected %b actual %b", $time, exp.error, e);
         mismatches++;
      end
      if (l !== exp.last) begin
         $display("%0t: last expected %b actual %b", $time, exp.last, l);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         check_output(rsp_ch.out_byte, rsp_ch.error, rsp_ch.last);
   end

   // receiver: long hold-offs on request, else stretches of steady or choppy acceptance
   initial begin
      int phase_left;
      int stall_left;
      bit choppy;
      phase_left = 0;
      stall_left = 0;
      choppy = 1'b0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_ch.ready = 1'b0;
            hold_left--;
         end else begin
            if (phase_left == 0) begin
               choppy = ($urandom_range(0, 2) != 0);
               phase_left = $urandom_range(20, 80);
            end
            phase_left--;
            if (stall_left > 0) begin
               rsp_ch.ready = 1'b0;
               stall_left--;
            end else if (choppy && $urandom_range(0, 3) == 0) begin
               rsp_ch.ready = 1'b0;
               stall_left = $urandom_range(0, 4);
            end else begin
               rsp_ch.ready = 1'b1;
            end
         end
      end
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("%0t: timeout, %0d outputs still awaited", $time, awaited_outputs.size());
      $display("base64_codec_with_line_wrap_core_test: done, errors");
      $finish;
   end

   task automatic test_encode_directed();
      send_item(CMD_DATA, 8'h00);
      send_item(CMD_DATA, 8'hFF);
      send_item(CMD_DATA, 8'hA5);
      send_end();
      send_end();
      settle();
      write_reg(CSR_WRAP_WIDTH, 16'd1);
      send_item(CMD_DATA, 8'hFF);
      send_end();
      settle();
      write_reg(CSR_WRAP_WIDTH, 16'd0);
      send_item(CMD_DATA, 8'h12);
      send_item(CMD_DATA, 8'h34);
      send_end();
   endtask

   task automatic test_decode_directed();
      settle();
      write_reg(CSR_DECODE_MODE, 16'd1);
      write_reg(CSR_IGNORE_GARBAGE, 16'd0);
      send_item(CMD_DATA, 8'h54);
      send_item(CMD_DATA, 8'h57);
      send_item(CMD_DATA, CharNewline);
      send_item(CMD_DATA, 8'h45);
      send_item(CMD_DATA, CharPad);
      send_end();
      // pad in first and second position, invalid character
      send_item(CMD_DATA, CharPad);
      send_end();
      send_item(CMD_DATA, 8'h51);
      send_item(CMD_DATA, CharPad);
      send_item(CMD_DATA, 8'h2A);
      send_end();
      settle();
      write_reg(CSR_IGNORE_GARBAGE, 16'd1);
      send_item(CMD_DATA, 8'hFF);
      send_item(CMD_DATA, 8'h51);
      send_item(CMD_DATA, 8'h51);
      send_item(CMD_DATA, CharPad);
      send_item(CMD_DATA, CharPad);
      send_item(CMD_DATA, 8'h42);
      send_end();
      // data after a third-position pad
      send_item(CMD_DATA, 8'h41);
      send_item(CMD_DATA, 8'h42);
      send_item(CMD_DATA, CharPad);
      send_item(CMD_DATA, 8'h43);
      send_end();
   endtask

   task automatic test_encode_random();
      int target;
      int len;
      logic [15:0] width;
      target = items_sent + 70;
      for (int n = 0; items_sent < target; n++) begin
         case (n == 0 ? 7 : n == 1 ? 0 : $urandom_range(0, 7))
            0: width = 16'd0;
            1: width = 16'd1;
            2: width = 16'd2;
            3: width = 16'd3;
            4: width = 16'd4;
            5: width = 16'd76;
            6: width = 16'($urandom_range(5, 24));
            default: width = 16'hFFFF;
         endcase
         settle();
         write_reg(CSR_DECODE_MODE, 16'd0);
         write_reg(CSR_WRAP_WIDTH, width);
         len = $urandom_range(0, 10);
         repeat (len) send_item(CMD_DATA, 8'($urandom_range(0, 255)));
         send_end();
      end
   endtask

   task automatic send_text_stream(input bit garbage_skipped);
      logic [7:0] text[$];
      int groups;
      groups = $urandom_range(0, 3);
      repeat (groups) repeat (4) text.push_back(random_symbol());
      case ($urandom_range(0, 3))
         0: repeat (4) text.push_back(random_symbol());
         1: begin
            repeat (3) text.push_back(random_symbol());
            text.push_back(CharPad);
         end
         2: begin
            repeat (2) text.push_back(random_symbol());
            repeat (2) text.push_back(CharPad);
         end
         default: ;
      endcase
      if (text.size() > 0 && $urandom_range(0, 7) == 0) void'(text.pop_back());
      foreach (text[i]) begin
         if ($urandom_range(0, 7) == 0) send_item(CMD_DATA, CharNewline);
         if ($urandom_range(0, garbage_skipped ? 4 : 30) == 0)
            send_item(CMD_DATA, 8'($urandom_range(0, 255)));
         send_item(CMD_DATA, text[i]);
      end
      send_end();
   endtask

   task automatic test_decode_random();
      int target;
      bit skip;
      target = items_sent + 75;
      settle();
      write_reg(CSR_DECODE_MODE, 16'd1);
      while (items_sent < target) begin
         skip = $urandom_range(0, 1);
         settle();
         write_reg(CSR_IGNORE_GARBAGE, {15'd0, skip});
         send_text_stream(skip);
      end
   endtask

   task automatic test_output_backpressure();
      settle();
      write_reg(CSR_DECODE_MODE, 16'd0);
      write_reg(CSR_WRAP_WIDTH, 16'd3);
      @(posedge clock);
      hold_left = 300;
      tx_no_gaps = 1'b1;
      repeat (28) send_item(CMD_DATA, 8'($urandom_range(0, 255)));
      send_end();
      tx_no_gaps = 1'b0;
   endtask

   task automatic test_mid_stream_changes();
      settle();
      write_reg(CSR_WRAP_WIDTH, 16'd76);
      send_item(CMD_DATA, 8'($urandom_range(0, 255)));
      send_item(CMD_DATA, 8'($urandom_range(0, 255)));
      settle();
      write_reg(CSR_WRAP_WIDTH, 16'd1);
      send_item(CMD_DATA, 8'($urandom_range(0, 255)));
      settle();
      write_reg(CSR_DECODE_MODE, 16'd1);
      repeat (3) send_item(CMD_DATA, random_symbol());
      settle();
      write_reg(CSR_DECODE_MODE, 16'd0);
      send_item(CMD_DATA, 8'($urandom_range(0, 255)));
      send_item(CMD_DATA, 8'($urandom_range(0, 255)));
      send_end();
   endtask

   initial begin
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.cmd = CMD_DATA;
      req_ch.in_byte = 8'h00;
      csr_ch.valid = 1'b0;
      csr_ch.index = CSR_DECODE_MODE;
      csr_ch.data = 16'h0000;
      mode_dec = 1'b0;
      ign_garbage = 1'b0;
      wrap_w = WrapWidthReset;
      clear_stream();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_encode_directed();
      test_decode_directed();
      test_encode_random();
      test_decode_random();
      test_output_backpressure();
      test_mid_stream_changes();

      @(negedge clock);
      req_ch.valid = 1'b0;
      for (int n = 0; n < DRAIN_LIMIT && awaited_outputs.size() != 0; n++)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (awaited_outputs.size() != 0) begin
         $display("%0t: %0d expected outputs never arrived", $time, awaited_outputs.size());
         mismatches += awaited_outputs.size();
      end

      $display("sent %0d transactions in %0d streams, checked %0d outputs",
               items_sent, streams_closed, outputs_checked);
      $display("encode and decode, wrap widths 0 to 65535, padding, garbage and backpressure");
      if (mismatches == 0) begin
         $display("base64_codec_with_line_wrap_core_test: done, clean");
      end else begin
         $display("base64_codec_with_line_wrap_core_test: done, errors");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/b64lw_pkg.sv
rtl/b64lw_intf.sv
rtl/b64lw_csr_regs.sv
rtl/b64lw_step.sv
rtl/b64lw_resbuf.sv
rtl/base64_codec_with_line_wrap_core.sv
tb/base64_codec_with_line_wrap_core_test.sv
